### design/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache tag store.
package dmwbc_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned BLOCK_BYTES = 32;
    localparam int unsigned NUM_LINES   = 128;
    localparam int unsigned OFFSET_W    = $clog2(BLOCK_BYTES);
    localparam int unsigned INDEX_W     = $clog2(NUM_LINES);
    localparam int unsigned BLOCK_W     = ADDR_W - OFFSET_W;
    localparam int unsigned TAG_W       = 20;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned LINE_W      = TAG_W + 1;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              func;
    } t_req;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLOCK_W-1:0]  block_number;
        logic [INDEX_W-1:0]  line_index;
        logic [TAG_W-1:0]    tag;
        logic                miss;
        logic                mem_read;
        logic                mem_write;
        logic                replacement;
        logic [TAG_W-1:0]    evicted_tag;
        logic [CNT_W-1:0]    hit_count;
        logic [CNT_W-1:0]    miss_count;
    } t_rsp;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### design/dmwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmwbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dmwbc_ctrl.sv
// Controller: request acceptance and lookup sequencing.
module dmwbc_ctrl import dmwbc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_stall   = 1'b1;
        o_cmd.load    = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_stall = 1'b0;
                o_cmd.load  = i_req_valid;
            end
            S_LOOKUP: begin
                o_cmd.commit = i_status.out_free;
            end
            default: o_req_stall = 1'b1;
        endcase
    end

endmodule

### design/dmwbc_dp.sv
// Datapath: address split, tag/dirty RAM, valid bits, counters, output register.
module dmwbc_dp import dmwbc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    input  logic    i_rsp_stall,
    output t_status o_status,
    output logic    o_rsp_valid,
    output t_rsp    o_rsp
);

    logic [ADDR_W-1:0]    r_addr;
    logic                 r_func;
    logic [NUM_LINES-1:0] r_line_valid;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp;

    logic [INDEX_W-1:0] req_idx;
    logic [INDEX_W-1:0] cur_idx;
    logic [TAG_W-1:0]   cur_tag;
    logic [INDEX_W-1:0] ram_raddr;
    logic [LINE_W-1:0]  ram_rdata;
    logic [TAG_W-1:0]   old_tag;
    logic               old_dirty;
    logic               line_v;
    logic               hit;
    logic               repl;
    logic               new_dirty;
    logic [CNT_W-1:0]   n_hits;
    logic [CNT_W-1:0]   n_misses;

    assign req_idx   = i_req.address[OFFSET_W +: INDEX_W];
    assign cur_idx   = r_addr[OFFSET_W +: INDEX_W];
    assign cur_tag   = r_addr[ADDR_W-1 -: TAG_W];
    assign ram_raddr = i_cmd.load ? req_idx : cur_idx;

    dmwbc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (cur_idx),
        .i_wdata ({new_dirty, cur_tag}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign old_tag   = ram_rdata[TAG_W-1:0];
    assign old_dirty = ram_rdata[TAG_W];
    assign line_v    = r_line_valid[cur_idx];
    assign hit       = line_v && (old_tag == cur_tag);
    assign repl      = !hit && line_v;
    // hit keeps the old dirty state; a write sets it; a read fill starts clean
    assign new_dirty = (hit && old_dirty) || (r_func == FUNC_WRITE);
    assign n_hits    = hit ? r_hits + 1'b1 : r_hits;
    assign n_misses  = hit ? r_misses : r_misses + 1'b1;

    assign o_status.out_free = !r_rsp_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_req.address;
            r_func <= i_req.func;
        end
        if (i_cmd.commit) begin
            r_rsp.byte_offset  <= r_addr[OFFSET_W-1:0];
            r_rsp.block_number <= r_addr[ADDR_W-1:OFFSET_W];
            r_rsp.line_index   <= cur_idx;
            r_rsp.tag          <= cur_tag;
            r_rsp.miss         <= !hit;
            r_rsp.mem_read     <= !hit;
            r_rsp.mem_write    <= repl && old_dirty;
            r_rsp.replacement  <= repl;
            r_rsp.evicted_tag  <= repl ? old_tag : '0;
            r_rsp.hit_count    <= n_hits;
            r_rsp.miss_count   <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_line_valid[cur_idx] <= 1'b1;
                r_hits                <= n_hits;
                r_misses              <= n_misses;
                r_rsp_valid           <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### design/direct_mapped_writeback_cache_tags_top.sv
// Sequence: a request is accepted in the idle state, which registers its address
// and the tag RAM read; the lookup state waits while the response register is
// held by a stalled output, then writes back the tag RAM and the response.
// A new request is accepted only after the lookup has committed.
// Reset: synchronous, active low; clears valid bits, counters and handshakes.
module direct_mapped_writeback_cache_tags_top import dmwbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_cmd    cmd;
    t_status status;

    dmwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_status    (status),
        .o_req_stall (o_req_stall),
        .o_cmd       (cmd)
    );

    dmwbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_rsp_stall (i_rsp_stall),
        .o_status    (status),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

`ifndef ASSERT_OFF
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("request accepted while lookup could restart");

    a_rsp_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(o_req_stall))
        else $error("response without a lookup");

    a_writeback_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.mem_write) |-> (o_rsp.replacement && o_rsp.miss))
        else $error("write-back without eviction");

    a_lookup_commits_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit) |=> !cmd.commit)
        else $error("lookup committed twice");
`endif

endmodule
